### src/apt_pkg.sv
package apt_pkg;

  localparam int OP_W       = 2;
  localparam int PTR_W      = 2;
  localparam int BODY_W     = 6;
  localparam int IN_COORD_W = 32;
  localparam int RANGE_W    = 31;
  localparam int CNT_W      = 3;
  localparam int PS_W       = 2;
  localparam int MODE_W     = 2;
  localparam int NUM_BOUNDS = 6;

  localparam logic [OP_W-1:0] OP_LOAD     = 2'd0;
  localparam logic [OP_W-1:0] OP_TEST     = 2'd1;
  localparam logic [OP_W-1:0] OP_CLASSIFY = 2'd2;

  localparam logic [PS_W-1:0] PS_NONE  = 2'd0;
  localparam logic [PS_W-1:0] PS_FIRST = 2'd1;
  localparam logic [PS_W-1:0] PS_STILL = 2'd2;

  localparam logic [MODE_W-1:0] MODE_APART = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NEW   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CONT  = 2'd2;

  localparam logic RK_TEST     = 1'b0;
  localparam logic RK_CLASSIFY = 1'b1;

  localparam logic [CNT_W-1:0] CNT_MAX = 3'd7;

  typedef enum logic [1:0] {
    K_LOAD,
    K_TEST,
    K_CLASSIFY
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [PTR_W-1:0]  ptr;
    logic [BODY_W-1:0] body;
  } cmd_t;

endpackage

### src/apt_ram.sv
module apt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### src/apt_fifo.sv
module apt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             full,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rd_ptr_r];

endmodule

### src/apt_front.sv
module apt_front #(
  parameter int MAX_SOLIDS   = 64,
  parameter int MAX_POINTERS = 4,
  parameter int COORD_BITS   = 32
) (
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  logic [apt_pkg::OP_W-1:0]                   in_operation,
  input  logic [apt_pkg::PTR_W-1:0]                  in_pointer_index,
  input  logic [apt_pkg::BODY_W-1:0]                 in_body_index,
  input  logic signed [apt_pkg::IN_COORD_W-1:0]      in_box_min_x,
  input  logic signed [apt_pkg::IN_COORD_W-1:0]      in_box_min_y,
  input  logic signed [apt_pkg::IN_COORD_W-1:0]      in_box_min_z,
  input  logic signed [apt_pkg::IN_COORD_W-1:0]      in_box_max_x,
  input  logic signed [apt_pkg::IN_COORD_W-1:0]      in_box_max_y,
  input  logic signed [apt_pkg::IN_COORD_W-1:0]      in_box_max_z,
  input  logic                                       in_pair_enabled,
  input  logic                                       in_is_pointer_body,
  input  logic [apt_pkg::RANGE_W-1:0]                proximity_range,
  input  logic                                       q_full,
  input  logic                                       clearing,
  output logic                                       q_push,
  output apt_pkg::cmd_t                              q_cmd,
  output logic [apt_pkg::NUM_BOUNDS*COORD_BITS-1:0]  q_coords
);

  import apt_pkg::*;

  localparam int WW = ((COORD_BITS > IN_COORD_W) ? COORD_BITS : IN_COORD_W) + 2;
  localparam logic signed [WW-1:0] C_HI = signed'((WW'(1) << (COORD_BITS - 1)) - WW'(1));
  localparam logic signed [WW-1:0] C_LO = -C_HI - WW'(1);

  function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [WW-1:0] v);
    logic signed [WW-1:0] r;
    r = v;
    if (v > C_HI) begin
      r = C_HI;
    end else if (v < C_LO) begin
      r = C_LO;
    end
    return COORD_BITS'(r);
  endfunction

  logic signed [IN_COORD_W-1:0] raw [NUM_BOUNDS];
  logic signed [COORD_BITS-1:0] clamped [NUM_BOUNDS];
  logic signed [COORD_BITS-1:0] grown [NUM_BOUNDS];
  logic signed [WW-1:0]         rng;
  logic                         body_ok;
  logic                         ptr_ok;
  logic                         keep;
  kind_t                        kind;

  assign raw[0] = in_box_min_x;
  assign raw[1] = in_box_min_y;
  assign raw[2] = in_box_min_z;
  assign raw[3] = in_box_max_x;
  assign raw[4] = in_box_max_y;
  assign raw[5] = in_box_max_z;

  assign rng = signed'(WW'(proximity_range));

  always_comb begin
    for (int i = 0; i < NUM_BOUNDS; i++) begin
      clamped[i] = sat(WW'(raw[i]));
      if (i < 3) begin
        grown[i] = sat(WW'(clamped[i]) - rng);
      end else begin
        grown[i] = sat(WW'(clamped[i]) + rng);
      end
    end
  end

  assign body_ok = (32'(in_body_index) < 32'(MAX_SOLIDS));
  assign ptr_ok  = (32'(in_pointer_index) < 32'(MAX_POINTERS));

  always_comb begin
    keep = 1'b0;
    kind = K_LOAD;
    case (in_operation)
      OP_LOAD: begin
        keep = 1'b1;
        kind = K_LOAD;
      end
      OP_TEST: begin
        keep = body_ok && ptr_ok && in_pair_enabled && !in_is_pointer_body;
        kind = K_TEST;
      end
      OP_CLASSIFY: begin
        keep = body_ok && !in_is_pointer_body;
        kind = K_CLASSIFY;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < NUM_BOUNDS; i++) begin
      q_coords[i*COORD_BITS +: COORD_BITS] = (kind == K_LOAD) ? grown[i] : clamped[i];
    end
  end

  assign in_ready   = !q_full && !clearing;
  assign q_push     = in_valid && in_ready && keep;
  assign q_cmd.kind = kind;
  assign q_cmd.ptr  = in_pointer_index;
  assign q_cmd.body = in_body_index;

endmodule

### src/apt_back.sv
module apt_back #(
  parameter int MAX_SOLIDS   = 64,
  parameter int MAX_POINTERS = 4,
  parameter int COORD_BITS   = 32
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      head_valid,
  input  apt_pkg::cmd_t                             head_cmd,
  input  logic [apt_pkg::NUM_BOUNDS*COORD_BITS-1:0] head_coords,
  output logic                                      pop,
  output logic                                      clearing,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic                                      out_result_kind,
  output logic [apt_pkg::BODY_W-1:0]                out_solid_number,
  output logic                                      out_is_near,
  output logic [apt_pkg::PS_W-1:0]                  out_pair_state,
  output logic [apt_pkg::MODE_W-1:0]                out_sim_mode
);

  import apt_pkg::*;

  localparam int PAIRS = MAX_POINTERS * MAX_SOLIDS;
  localparam int PW    = $clog2(PAIRS);
  localparam int SW    = $clog2(MAX_SOLIDS);
  localparam int CTRW  = 2 * CNT_W;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_RUN,
    S_UPD
  } state_t;

  state_t                       state_r, state_nxt;
  logic [PW-1:0]                clr_r, clr_nxt;
  logic signed [COORD_BITS-1:0] pbox_r [NUM_BOUNDS];
  logic signed [COORD_BITS-1:0] pbox_nxt [NUM_BOUNDS];
  logic [BODY_W-1:0]            pbody_r, pbody_nxt;
  kind_t                        kind_r, kind_nxt;
  logic [BODY_W-1:0]            body_r, body_nxt;
  logic [PW-1:0]                pidx_r, pidx_nxt;
  logic                         near_r, near_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_kind_r, out_kind_nxt;
  logic [BODY_W-1:0]            out_body_r, out_body_nxt;
  logic                         out_near_r, out_near_nxt;
  logic [PS_W-1:0]              out_ps_r, out_ps_nxt;
  logic [MODE_W-1:0]            out_mode_r, out_mode_nxt;

  logic signed [COORD_BITS-1:0] scrd [NUM_BOUNDS];
  logic [2:0]                   axis_ov;
  logic                         near_now;
  logic [PW-1:0]                pidx_head;
  logic                         slot_free;

  logic                         pair_we, pair_re;
  logic [PW-1:0]                pair_waddr;
  logic [PS_W-1:0]              pair_wdata, pair_rdata;
  logic                         ctr_we, ctr_re;
  logic [SW-1:0]                ctr_waddr;
  logic [CTRW-1:0]              ctr_wdata, ctr_rdata;
  logic [CNT_W-1:0]             first_cnt, still_cnt;
  logic [PS_W-1:0]              ps_new;

  apt_ram #(.WIDTH(PS_W), .DEPTH(PAIRS)) u_pair_ram (
    .clk     (clk),
    .wr_en   (pair_we),
    .wr_addr (pair_waddr),
    .wr_data (pair_wdata),
    .rd_en   (pair_re),
    .rd_addr (pidx_head),
    .rd_data (pair_rdata)
  );

  apt_ram #(.WIDTH(CTRW), .DEPTH(MAX_SOLIDS)) u_ctr_ram (
    .clk     (clk),
    .wr_en   (ctr_we),
    .wr_addr (ctr_waddr),
    .wr_data (ctr_wdata),
    .rd_en   (ctr_re),
    .rd_addr (SW'(head_cmd.body)),
    .rd_data (ctr_rdata)
  );

  always_comb begin
    for (int i = 0; i < NUM_BOUNDS; i++) begin
      scrd[i] = $signed(head_coords[i*COORD_BITS +: COORD_BITS]);
    end
    for (int a = 0; a < 3; a++) begin
      axis_ov[a] = (pbox_r[a] <= scrd[a]   && scrd[a]     <= pbox_r[a+3]) ||
                   (pbox_r[a] <= scrd[a+3] && scrd[a+3]   <= pbox_r[a+3]) ||
                   (scrd[a]   <= pbox_r[a] && pbox_r[a]   <= scrd[a+3])   ||
                   (scrd[a]   <= pbox_r[a+3] && pbox_r[a+3] <= scrd[a+3]);
    end
  end

  assign near_now  = &axis_ov;
  assign pidx_head = PW'(PW'(head_cmd.ptr) * PW'(MAX_SOLIDS)) + PW'(head_cmd.body);
  assign slot_free = !out_valid_r || out_ready;
  assign first_cnt = ctr_rdata[CTRW-1:CNT_W];
  assign still_cnt = ctr_rdata[CNT_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    pbox_nxt      = pbox_r;
    pbody_nxt     = pbody_r;
    kind_nxt      = kind_r;
    body_nxt      = body_r;
    pidx_nxt      = pidx_r;
    near_nxt      = near_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt  = out_kind_r;
    out_body_nxt  = out_body_r;
    out_near_nxt  = out_near_r;
    out_ps_nxt    = out_ps_r;
    out_mode_nxt  = out_mode_r;
    pop           = 1'b0;
    pair_re       = 1'b0;
    ctr_re        = 1'b0;
    pair_we       = 1'b0;
    ctr_we        = 1'b0;
    pair_waddr    = pidx_r;
    pair_wdata    = PS_NONE;
    ctr_waddr     = SW'(body_r);
    ctr_wdata     = '0;
    ps_new        = PS_NONE;
    case (state_r)
      S_CLEAR: begin
        pair_we    = 1'b1;
        pair_waddr = clr_r;
        ctr_we     = ((PW + 1)'(clr_r) < (PW + 1)'(MAX_SOLIDS));
        ctr_waddr  = SW'(clr_r);
        if (clr_r == PW'(PAIRS - 1)) begin
          state_nxt = S_RUN;
        end else begin
          clr_nxt = clr_r + PW'(1);
        end
      end
      S_RUN: begin
        if (head_valid) begin
          pop = 1'b1;
          case (head_cmd.kind)
            K_LOAD: begin
              for (int i = 0; i < NUM_BOUNDS; i++) begin
                pbox_nxt[i] = scrd[i];
              end
              pbody_nxt = head_cmd.body;
            end
            K_TEST: begin
              if (head_cmd.body != pbody_r) begin
                pair_re   = 1'b1;
                ctr_re    = 1'b1;
                kind_nxt  = K_TEST;
                body_nxt  = head_cmd.body;
                pidx_nxt  = pidx_head;
                near_nxt  = near_now;
                state_nxt = S_UPD;
              end
            end
            K_CLASSIFY: begin
              ctr_re    = 1'b1;
              kind_nxt  = K_CLASSIFY;
              body_nxt  = head_cmd.body;
              state_nxt = S_UPD;
            end
            default: begin
              pop = 1'b1;
            end
          endcase
        end
      end
      S_UPD: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_body_nxt  = body_r;
          state_nxt     = S_RUN;
          if (kind_r == K_TEST) begin
            if (near_r) begin
              if (pair_rdata == PS_NONE) begin
                ps_new    = PS_FIRST;
                ctr_wdata = {(first_cnt == CNT_MAX) ? first_cnt : first_cnt + CNT_W'(1),
                             still_cnt};
              end else begin
                ps_new    = PS_STILL;
                ctr_wdata = {first_cnt,
                             (still_cnt == CNT_MAX) ? still_cnt : still_cnt + CNT_W'(1)};
              end
              ctr_we = 1'b1;
            end
            pair_we      = 1'b1;
            pair_wdata   = ps_new;
            out_kind_nxt = RK_TEST;
            out_near_nxt = near_r;
            out_ps_nxt   = ps_new;
            out_mode_nxt = MODE_APART;
          end else begin
            ctr_we       = 1'b1;
            ctr_wdata    = '0;
            out_kind_nxt = RK_CLASSIFY;
            out_near_nxt = 1'b0;
            out_ps_nxt   = PS_NONE;
            if (still_cnt == '0 && first_cnt != '0) begin
              out_mode_nxt = MODE_NEW;
            end else if (still_cnt != '0) begin
              out_mode_nxt = MODE_CONT;
            end else begin
              out_mode_nxt = MODE_APART;
            end
          end
        end
      end
      default: begin
        state_nxt = S_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      pbody_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_BOUNDS; i++) begin
        pbox_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pbody_r     <= pbody_nxt;
      out_valid_r <= out_valid_nxt;
      pbox_r      <= pbox_nxt;
    end
    kind_r     <= kind_nxt;
    body_r     <= body_nxt;
    pidx_r     <= pidx_nxt;
    near_r     <= near_nxt;
    out_kind_r <= out_kind_nxt;
    out_body_r <= out_body_nxt;
    out_near_r <= out_near_nxt;
    out_ps_r   <= out_ps_nxt;
    out_mode_r <= out_mode_nxt;
  end

  assign clearing         = (state_r == S_CLEAR);
  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_kind_r;
  assign out_solid_number = out_body_r;
  assign out_is_near      = out_near_r;
  assign out_pair_state   = out_ps_r;
  assign out_sim_mode     = out_mode_r;

  a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid && state_r == S_RUN)
    else $error("queue popped without a waiting beat");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !out_valid_r)
    else $error("result beat during clearing pass");

  a_test_near_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == RK_TEST |-> out_near_r == (out_ps_r != PS_NONE))
    else $error("test beat near flag disagrees with pair state");

  a_classify_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == RK_CLASSIFY |-> !out_near_r && out_ps_r == PS_NONE)
    else $error("classify beat carries test fields");

  a_upd_completes: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_UPD && slot_free |=> state_r == S_RUN && out_valid_r)
    else $error("update did not deliver a result beat");

endmodule

### src/aabb_proximity_tracker_core.sv
// Path: a test or classify passes the queue, reads the pair and counter RAMs in S_RUN,
//   writes them and registers its result on out_valid in S_UPD; a load passes the queue
//   into the pointer box. Throughput: no beat is popped in S_UPD; one load per cycle in
//   S_RUN; a 2-entry queue decouples input from the update engine.
// Reset: rst_n (sync, active low) zeroes range, pointer box and body; then a clearing pass
//   over all MAX_POINTERS*MAX_SOLIDS pair entries (256 by default) holds in_ready low.
module aabb_proximity_tracker_core #(
  parameter int MAX_SOLIDS   = 64,
  parameter int MAX_POINTERS = 4,
  parameter int COORD_BITS   = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [apt_pkg::RANGE_W-1:0]           cfg_wr_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [apt_pkg::OP_W-1:0]              in_operation,
  input  logic [apt_pkg::PTR_W-1:0]             in_pointer_index,
  input  logic [apt_pkg::BODY_W-1:0]            in_body_index,
  input  logic signed [apt_pkg::IN_COORD_W-1:0] in_box_min_x,
  input  logic signed [apt_pkg::IN_COORD_W-1:0] in_box_min_y,
  input  logic signed [apt_pkg::IN_COORD_W-1:0] in_box_min_z,
  input  logic signed [apt_pkg::IN_COORD_W-1:0] in_box_max_x,
  input  logic signed [apt_pkg::IN_COORD_W-1:0] in_box_max_y,
  input  logic signed [apt_pkg::IN_COORD_W-1:0] in_box_max_z,
  input  logic                                  in_pair_enabled,
  input  logic                                  in_is_pointer_body,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_result_kind,
  output logic [apt_pkg::BODY_W-1:0]            out_solid_number,
  output logic                                  out_is_near,
  output logic [apt_pkg::PS_W-1:0]              out_pair_state,
  output logic [apt_pkg::MODE_W-1:0]            out_sim_mode
);

  import apt_pkg::*;

  localparam int CRD_W = NUM_BOUNDS * COORD_BITS;
  localparam int QW    = $bits(cmd_t) + CRD_W;
  localparam int QD    = 2;

  logic [RANGE_W-1:0] proximity_range_r;
  logic               q_push, q_pop, q_full, q_head_valid, clearing;
  cmd_t               q_cmd, head_cmd;
  logic [CRD_W-1:0]   q_coords, head_coords;
  logic [QW-1:0]      head_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proximity_range_r <= '0;
    end else if (cfg_wr_en) begin
      proximity_range_r <= cfg_wr_data;
    end
  end

  apt_front #(
    .MAX_SOLIDS   (MAX_SOLIDS),
    .MAX_POINTERS (MAX_POINTERS),
    .COORD_BITS   (COORD_BITS)
  ) u_front (
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_pointer_index   (in_pointer_index),
    .in_body_index      (in_body_index),
    .in_box_min_x       (in_box_min_x),
    .in_box_min_y       (in_box_min_y),
    .in_box_min_z       (in_box_min_z),
    .in_box_max_x       (in_box_max_x),
    .in_box_max_y       (in_box_max_y),
    .in_box_max_z       (in_box_max_z),
    .in_pair_enabled    (in_pair_enabled),
    .in_is_pointer_body (in_is_pointer_body),
    .proximity_range    (proximity_range_r),
    .q_full             (q_full),
    .clearing           (clearing),
    .q_push             (q_push),
    .q_cmd              (q_cmd),
    .q_coords           (q_coords)
  );

  apt_fifo #(.WIDTH(QW), .DEPTH(QD)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  ({q_cmd, q_coords}),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head_data  (head_data)
  );

  assign head_cmd    = cmd_t'(head_data[QW-1:CRD_W]);
  assign head_coords = head_data[CRD_W-1:0];

  apt_back #(
    .MAX_SOLIDS   (MAX_SOLIDS),
    .MAX_POINTERS (MAX_POINTERS),
    .COORD_BITS   (COORD_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (q_head_valid),
    .head_cmd         (head_cmd),
    .head_coords      (head_coords),
    .pop              (q_pop),
    .clearing         (clearing),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_kind  (out_result_kind),
    .out_solid_number (out_solid_number),
    .out_is_near      (out_is_near),
    .out_pair_state   (out_pair_state),
    .out_sim_mode     (out_sim_mode)
  );

endmodule

### test/tb_aabb_proximity_tracker_core.sv
module tb_aabb_proximity_tracker_core;
  import apt_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam longint COORD_MAX = 64'sd2147483647;
  localparam longint COORD_MIN = -64'sd2147483648;
  localparam int SOLIDS = 64;
  localparam int POINTERS = 4;
  localparam int SETTLE = 12;
  localparam int PHASE_BEATS = 390;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [OP_W-1:0]                        op;
    logic [PTR_W-1:0]                       ptr;
    logic [BODY_W-1:0]                      body;
    logic [NUM_BOUNDS-1:0][IN_COORD_W-1:0]  bnd;
    logic                                   en;
    logic                                   pb;
  } beat_t;

  typedef struct packed {
    logic              rk;
    logic [BODY_W-1:0] solid;
    logic              near;
    logic [PS_W-1:0]   ps;
    logic [MODE_W-1:0] mode;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [RANGE_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OP_W-1:0] in_operation = OP_LOAD;
  logic [PTR_W-1:0] in_pointer_index = '0;
  logic [BODY_W-1:0] in_body_index = '0;
  logic signed [IN_COORD_W-1:0] in_box_min_x = '0;
  logic signed [IN_COORD_W-1:0] in_box_min_y = '0;
  logic signed [IN_COORD_W-1:0] in_box_min_z = '0;
  logic signed [IN_COORD_W-1:0] in_box_max_x = '0;
  logic signed [IN_COORD_W-1:0] in_box_max_y = '0;
  logic signed [IN_COORD_W-1:0] in_box_max_z = '0;
  logic in_pair_enabled = 1'b0;
  logic in_is_pointer_body = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_result_kind;
  logic [BODY_W-1:0] out_solid_number;
  logic out_is_near;
  logic [PS_W-1:0] out_pair_state;
  logic [MODE_W-1:0] out_sim_mode;

  always #1 clk = ~clk;

  aabb_proximity_tracker_core i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_pointer_index   (in_pointer_index),
    .in_body_index      (in_body_index),
    .in_box_min_x       (in_box_min_x),
    .in_box_min_y       (in_box_min_y),
    .in_box_min_z       (in_box_min_z),
    .in_box_max_x       (in_box_max_x),
    .in_box_max_y       (in_box_max_y),
    .in_box_max_z       (in_box_max_z),
    .in_pair_enabled    (in_pair_enabled),
    .in_is_pointer_body (in_is_pointer_body),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_result_kind    (out_result_kind),
    .out_solid_number   (out_solid_number),
    .out_is_near        (out_is_near),
    .out_pair_state     (out_pair_state),
    .out_sim_mode       (out_sim_mode)
  );

  // tracker shadow state
  logic [RANGE_W-1:0] margin;
  longint grown_box[NUM_BOUNDS];
  logic [BODY_W-1:0] anchor_body;
  logic [PS_W-1:0] pair_mem[POINTERS*SOLIDS];
  logic [CNT_W-1:0] first_cnt[SOLIDS];
  logic [CNT_W-1:0] still_cnt[SOLIDS];

  result_t pending_results[$];
  result_t head;
  longint world[3];
  bit steady = 1'b0;
  int errors = 0;
  int cycle_count = 0;
  int stall_left = 0;

  function automatic int pause_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic longint sat32(input longint v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  function automatic longint to_coord(input logic [IN_COORD_W-1:0] v);
    return longint'($signed(v));
  endfunction

  function automatic bit axis_hits(input longint pmin, input longint pmax,
                                   input longint smin, input longint smax);
    return (pmin <= smin && smin <= pmax) || (pmin <= smax && smax <= pmax) ||
           (smin <= pmin && pmin <= smax) || (smin <= pmax && pmax <= smax);
  endfunction

  task automatic predict_beat(input beat_t b);
    result_t r;
    bit hit;
    int idx;
    r = '0;
    case (b.op)
      OP_LOAD: begin
        for (int a = 0; a < 3; a++) begin
          grown_box[a] = sat32(to_coord(b.bnd[a]) - longint'(margin));
          grown_box[3+a] = sat32(to_coord(b.bnd[3+a]) + longint'(margin));
        end
        anchor_body = b.body;
      end
      OP_TEST: begin
        if (b.body != anchor_body && !b.pb && b.en) begin
          hit = 1'b1;
          for (int a = 0; a < 3; a++)
            if (!axis_hits(grown_box[a], grown_box[3+a], to_coord(b.bnd[a]),
                           to_coord(b.bnd[3+a])))
              hit = 1'b0;
          idx = int'(b.ptr) * SOLIDS + int'(b.body);
          if (!hit) begin
            r.ps = PS_NONE;
          end else if (pair_mem[idx] == PS_NONE) begin
            r.ps = PS_FIRST;
            if (first_cnt[b.body] != CNT_MAX) first_cnt[b.body]++;
          end else begin
            r.ps = PS_STILL;
            if (still_cnt[b.body] != CNT_MAX) still_cnt[b.body]++;
          end
          pair_mem[idx] = r.ps;
          r.rk = RK_TEST;
          r.solid = b.body;
          r.near = hit;
          r.mode = MODE_APART;
          pending_results = {pending_results, r};
        end
      end
      OP_CLASSIFY: begin
        if (!b.pb) begin
          if (still_cnt[b.body] == 0 && first_cnt[b.body] != 0) r.mode = MODE_NEW;
          else if (still_cnt[b.body] != 0) r.mode = MODE_CONT;
          else r.mode = MODE_APART;
          first_cnt[b.body] = '0;
          still_cnt[b.body] = '0;
          r.rk = RK_CLASSIFY;
          r.solid = b.body;
          r.near = 1'b0;
          r.ps = PS_NONE;
          pending_results = {pending_results, r};
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_beat(input beat_t b);
    int gap;
    gap = pause_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= b.op;
    in_pointer_index <= b.ptr;
    in_body_index <= b.body;
    in_box_min_x <= b.bnd[0];
    in_box_min_y <= b.bnd[1];
    in_box_min_z <= b.bnd[2];
    in_box_max_x <= b.bnd[3];
    in_box_max_y <= b.bnd[4];
    in_box_max_z <= b.bnd[5];
    in_pair_enabled <= b.en;
    in_is_pointer_body <= b.pb;
    do @(posedge clk); while (!in_ready);
    predict_beat(b);
  endtask

  task automatic drain(input int settle);
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (pending_results.size() > 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() > 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      errors++;
      pending_results.delete();
    end
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_margin(input logic [RANGE_W-1:0] v);
    drain(SETTLE);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    margin = v;
  endtask

  function automatic beat_t mk(input logic [OP_W-1:0] op, input int ptr, input int body,
                               input longint lo, input longint hi, input logic en,
                               input logic pb);
    beat_t b;
    b.op = op;
    b.ptr = PTR_W'(ptr);
    b.body = BODY_W'(body);
    for (int a = 0; a < 3; a++) begin
      b.bnd[a] = lo[IN_COORD_W-1:0];
      b.bnd[3+a] = hi[IN_COORD_W-1:0];
    end
    b.en = en;
    b.pb = pb;
    return b;
  endfunction

  function automatic logic [NUM_BOUNDS-1:0][IN_COORD_W-1:0] box_around(input longint spread,
                                                                       input longint half);
    logic [NUM_BOUNDS-1:0][IN_COORD_W-1:0] bx;
    longint c, h, lo, hi, t;
    for (int a = 0; a < 3; a++) begin
      c = world[a] + longint'($urandom_range(0, int'(2 * spread))) - spread;
      h = longint'($urandom_range(0, int'(half)));
      lo = sat32(c - h);
      hi = sat32(c + h);
      if ($urandom_range(0, 19) == 0) begin
        t = lo;
        lo = hi;
        hi = t;
      end
      bx[a] = lo[IN_COORD_W-1:0];
      bx[3+a] = hi[IN_COORD_W-1:0];
    end
    return bx;
  endfunction

  task automatic pick_center();
    for (int a = 0; a < 3; a++) begin
      if ($urandom_range(0, 4) == 0)
        world[a] = ($urandom_range(0, 1) != 0) ? COORD_MAX - longint'($urandom_range(0, 4096))
                                              : COORD_MIN + longint'($urandom_range(0, 4096));
      else
        world[a] = longint'($urandom_range(0, 1 << 25)) - (longint'(1) << 24);
    end
  endtask

  task automatic test_overlap_bounds();
    beat_t b;
    send_beat(mk(OP_LOAD, 0, 10, 0, 100, 1'b1, 1'b0));
    send_beat(mk(OP_TEST, 0, 1, 100, 200, 1'b1, 1'b0));    // touches upper bound
    send_beat(mk(OP_TEST, 0, 1, 100, 200, 1'b1, 1'b0));    // continuing
    b = mk(OP_TEST, 0, 1, 100, 200, 1'b1, 1'b0);
    b.bnd[0] = 32'd101;                                    // x one past
    send_beat(b);
    send_beat(mk(OP_TEST, 1, 1, -50, 0, 1'b1, 1'b0));      // touches lower bound
    send_beat(mk(OP_TEST, 0, 2, -100, -1, 1'b1, 1'b0));
    send_beat(mk(OP_TEST, 0, 2, 50, -500, 1'b1, 1'b0));    // inverted box, bound inside
    send_beat(mk(OP_TEST, 2, 4, 200, -200, 1'b1, 1'b0));   // inverted box, no hit
    send_beat(mk(OP_TEST, 0, 3, -1000, 1000, 1'b1, 1'b0)); // pointer inside solid
    send_beat(mk(OP_LOAD, 0, 63, COORD_MIN, COORD_MAX, 1'b1, 1'b0));
    send_beat(mk(OP_TEST, 3, 0, COORD_MAX, COORD_MAX, 1'b1, 1'b0));
    send_beat(mk(OP_TEST, 3, 62, COORD_MIN, COORD_MIN, 1'b1, 1'b0));
  endtask

  task automatic test_skipped_items();
    send_beat(mk(OP_LOAD, 2, 10, 0, 100, 1'b0, 1'b1));
    send_beat(mk(OP_TEST, 0, 10, 0, 100, 1'b1, 1'b0));     // own body
    send_beat(mk(OP_TEST, 0, 5, 0, 100, 1'b1, 1'b1));      // pointer body
    send_beat(mk(OP_TEST, 0, 5, 0, 100, 1'b0, 1'b0));      // pair off
    send_beat(mk(OP_UNUSED, 3, 5, 0, 100, 1'b1, 1'b0));
    send_beat(mk(OP_CLASSIFY, 0, 5, 0, 0, 1'b1, 1'b1));
    send_beat(mk(OP_TEST, 0, 5, 0, 100, 1'b1, 1'b0));      // still a first hit
  endtask

  task automatic test_classify_modes();
    send_beat(mk(OP_CLASSIFY, 0, 1, 0, 0, 1'b1, 1'b0));
    send_beat(mk(OP_CLASSIFY, 0, 1, 0, 0, 1'b1, 1'b0));
    send_beat(mk(OP_CLASSIFY, 0, 2, 0, 0, 1'b1, 1'b0));
    send_beat(mk(OP_CLASSIFY, 0, 10, 0, 0, 1'b0, 1'b0));
  endtask

  task automatic test_counter_saturation();
    for (int i = 0; i < 9; i++)
      send_beat(mk(OP_TEST, 3, 50, 10, 20, 1'b1, 1'b0));
    send_beat(mk(OP_CLASSIFY, 3, 50, 0, 0, 1'b1, 1'b0));
  endtask

  task automatic test_margin_growth();
    write_margin({RANGE_W{1'b1}});
    send_beat(mk(OP_LOAD, 0, 9, 0, 0, 1'b1, 1'b0));
    send_beat(mk(OP_TEST, 0, 20, COORD_MAX, COORD_MAX, 1'b1, 1'b0));
    send_beat(mk(OP_TEST, 1, 21, COORD_MIN, COORD_MIN, 1'b1, 1'b0));
    write_margin(RANGE_W'(1 << 16));
    send_beat(mk(OP_LOAD, 0, 9, 0, 0, 1'b1, 1'b0));
    send_beat(mk(OP_TEST, 0, 22, 65536, 70000, 1'b1, 1'b0));
    send_beat(mk(OP_TEST, 0, 23, 65537, 70000, 1'b1, 1'b0));
    send_beat(mk(OP_CLASSIFY, 0, 20, 0, 0, 1'b1, 1'b0));
  endtask

  task automatic test_random_traffic();
    logic [RANGE_W-1:0] margins[5];
    beat_t b;
    int body_base, pick;
    margins[0] = '0;
    margins[1] = RANGE_W'($urandom_range(0, 1 << 15));
    margins[2] = RANGE_W'(1 << 14);
    margins[3] = {RANGE_W{1'b1}};
    margins[4] = RANGE_W'($urandom);
    body_base = 0;
    pick_center();
    for (int p = 0; p < 5; p++) begin
      write_margin(margins[p]);
      for (int k = 0; k < PHASE_BEATS; k++) begin
        if (k % 40 == 0) begin
          steady = ($urandom_range(0, 4) == 0);
          body_base = $urandom_range(0, SOLIDS - 1);
        end
        pick = $urandom_range(0, 99);
        b.ptr = PTR_W'($urandom_range(0, POINTERS - 1));
        b.body = BODY_W'(body_base + $urandom_range(0, 7));
        b.en = ($urandom_range(0, 9) != 0);
        b.pb = ($urandom_range(0, 14) == 0);
        if (pick < 6) begin
          pick_center();
          b.op = OP_LOAD;
          b.body = BODY_W'($urandom_range(0, SOLIDS - 1));
          b.bnd = box_around(512, 1 << 15);
        end else if (pick < 72) begin
          b.op = OP_TEST;
          b.bnd = box_around(1 << 16, 1 << 15);
        end else if (pick < 92) begin
          b.op = OP_CLASSIFY;
          b.bnd = box_around(1 << 16, 1 << 15);
        end else begin
          b.op = OP_W'($urandom_range(0, 3));
          for (int a = 0; a < NUM_BOUNDS; a++) b.bnd[a] = $urandom;
          b.en = 1'($urandom_range(0, 1));
          b.pb = 1'($urandom_range(0, 1));
        end
        send_beat(b);
      end
    end
    steady = 1'b0;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL aabb_proximity_tracker_core");
      $finish;
    end
  end

  // result beat check and out_ready stalls
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected beat, solid_number %0d", $time, out_solid_number);
        errors++;
      end else begin
        head = pending_results.pop_front();
        if (out_result_kind !== head.rk) begin
          $display("%0t: result_kind expected %0d actual %0d", $time, head.rk, out_result_kind);
          errors++;
        end
        if (out_solid_number !== head.solid) begin
          $display("%0t: solid_number expected %0d actual %0d", $time, head.solid,
                   out_solid_number);
          errors++;
        end
        if (out_is_near !== head.near) begin
          $display("%0t: is_near expected %0d actual %0d", $time, head.near, out_is_near);
          errors++;
        end
        if (out_pair_state !== head.ps) begin
          $display("%0t: pair_state expected %0d actual %0d", $time, head.ps, out_pair_state);
          errors++;
        end
        if (out_sim_mode !== head.mode) begin
          $display("%0t: sim_mode expected %0d actual %0d", $time, head.mode, out_sim_mode);
          errors++;
        end
      end
    end
    if (!steady && stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!steady && $urandom_range(0, 3) == 0) stall_left = pause_len();
    end
  end

  initial begin
    margin = '0;
    anchor_body = '0;
    for (int i = 0; i < NUM_BOUNDS; i++) grown_box[i] = 0;
    for (int i = 0; i < POINTERS * SOLIDS; i++) pair_mem[i] = PS_NONE;
    for (int i = 0; i < SOLIDS; i++) begin
      first_cnt[i] = '0;
      still_cnt[i] = '0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    write_margin('0);
    test_overlap_bounds();
    test_skipped_items();
    test_classify_modes();
    test_counter_saturation();
    test_margin_growth();
    test_random_traffic();
    drain(SETTLE);
    if (errors == 0) $display("PASS aabb_proximity_tracker_core");
    else $display("FAIL aabb_proximity_tracker_core");
    $finish;
  end

endmodule

### aabb_proximity_tracker_core.f
src/apt_pkg.sv
src/apt_ram.sv
src/apt_fifo.sv
src/apt_front.sv
src/apt_back.sv
src/aabb_proximity_tracker_core.sv
test/tb_aabb_proximity_tracker_core.sv
